// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared sizes, codes and types of the pooled list set.
// ----------------------------------------------------------------------------
package pls_pkg;

   // storage sizes
   localparam int NUM_CELLS  = 1024;
   localparam int POOL_DEPTH = 8192;

   localparam int CELL_W = $clog2(NUM_CELLS);
   localparam int NODE_W = $clog2(POOL_DEPTH);
   localparam int CNT_W  = NODE_W + 1;

   // field widths
   localparam int OP_W     = 3;
   localparam int INDEX_W  = 10;
   localparam int ELEM_W   = 20;
   localparam int STATUS_W = 3;

   // memory words: head = {valid, node}, node = {element, link, link valid}
   localparam int HEAD_W = NODE_W + 1;
   localparam int NODE_WORD_W = ELEM_W + NODE_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR     = 3'd0,
      OP_PUSH      = 3'd1,
      OP_START     = 3'd2,
      OP_NEXT      = 3'd3,
      OP_POOL_RST  = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_END      = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_HEAD,
      S_WALK,
      S_ITER,
      S_ALLOC,
      S_LINK,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/pls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pooled_list_set_append.sv =====
`timescale 1ns / 1ps
// Flow: clear, reset pool, unused opcodes and a read past the tail go to finish;
//   start iteration and read next pass a head or node read first; a push reads
//   the head, walks the list, fills an empty head, reports full or links a tail.
// Throughput: one request at a time, the next accepted once the result sits in
//   the output register.
// Reset: a sweep over all NUM_CELLS heads marks every head empty with requests stalled.
// ----------------------------------------------------------------------------
// pooled_list_set_append
// Per-cell singly linked lists sharing one bump-allocated node pool, with
// set-style push, clear, pool reset, and a shared iteration cursor.
// ----------------------------------------------------------------------------
module pooled_list_set_append
   import pls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [INDEX_W-1:0]  req_cell_index,
   input  logic [ELEM_W-1:0]   req_element_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ELEM_W-1:0]   rsp_read_element,
   output logic                rsp_read_valid
);

   // control registers
   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [CNT_W-1:0]   pool_used_ff, pool_used_in;
   logic               cursor_valid_ff, cursor_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   opcode_type         op_ff, op_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [ELEM_W-1:0]  elem_ff, elem_in;
   logic [NODE_W-1:0]  cursor_ff, cursor_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [NODE_W-1:0]  prev_ff, prev_in;
   logic [ELEM_W-1:0]  prev_elem_ff, prev_elem_in;
   logic [NODE_W-1:0]  new_node_ff, new_node_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   status_type         res_status_ff, res_status_in;
   logic [ELEM_W-1:0]  res_elem_ff, res_elem_in;
   logic               res_rv_ff, res_rv_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ELEM_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic               rsp_rv_ff, rsp_rv_in;

   // memory ports
   logic                   head_we;
   logic [CELL_W-1:0]      head_waddr;
   logic [HEAD_W-1:0]      head_wdata;
   logic [CELL_W-1:0]      head_raddr;
   logic [HEAD_W-1:0]      head_rdata;
   logic                   node_we;
   logic [NODE_W-1:0]      node_waddr;
   logic [NODE_WORD_W-1:0] node_wdata;
   logic [NODE_W-1:0]      node_raddr;
   logic [NODE_WORD_W-1:0] node_rdata;

   // unpacked read data
   logic               head_valid;
   logic [NODE_W-1:0]  head_node;
   logic [ELEM_W-1:0]  rd_elem;
   logic [NODE_W-1:0]  rd_link;
   logic               rd_link_valid;
   logic               accept;
   logic               out_free;

   assign head_valid    = head_rdata[HEAD_W-1];
   assign head_node     = head_rdata[NODE_W-1:0];
   assign rd_elem       = node_rdata[NODE_WORD_W-1 -: ELEM_W];
   assign rd_link       = node_rdata[NODE_W:1];
   assign rd_link_valid = node_rdata[0];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   pls_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_CELLS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   pls_ram #(.WIDTH(NODE_WORD_W), .DEPTH(POOL_DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   // next state, memory control and result
   always_comb begin
      state_in        = state_ff;
      init_cnt_in     = init_cnt_ff;
      pool_used_in    = pool_used_ff;
      cursor_valid_in = cursor_valid_ff;
      op_in           = op_ff;
      cell_in         = cell_ff;
      elem_in         = elem_ff;
      cursor_in       = cursor_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      prev_elem_in    = prev_elem_ff;
      new_node_in     = new_node_ff;
      steps_in        = steps_ff;
      res_status_in   = res_status_ff;
      res_elem_in     = res_elem_ff;
      res_rv_in       = res_rv_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_elem_in     = rsp_elem_ff;
      rsp_rv_in       = rsp_rv_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      head_we    = 1'b0;
      head_waddr = cell_ff;
      head_wdata = '0;
      head_raddr = CELL_W'(req_cell_index);
      node_we    = 1'b0;
      node_waddr = pool_used_ff[NODE_W-1:0];
      node_wdata = {elem_ff, {NODE_W{1'b0}}, 1'b0};
      node_raddr = cursor_ff;

      case (state_ff)
         // mark every head empty after reset
         S_INIT: begin
            head_we     = 1'b1;
            head_waddr  = init_cnt_ff;
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == CELL_W'(NUM_CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a request and start its first memory access, if it has one
         S_IDLE: begin
            if (accept) begin
               op_in         = opcode_type'(req_opcode);
               cell_in       = CELL_W'(req_cell_index);
               elem_in       = req_element_value;
               res_status_in = ST_DONE;
               res_elem_in   = '0;
               res_rv_in     = 1'b0;
               state_in      = S_FINISH;
               case (opcode_type'(req_opcode))
                  OP_CLEAR: begin
                     head_we    = 1'b1;
                     head_waddr = CELL_W'(req_cell_index);
                  end
                  OP_PUSH, OP_START: begin
                     state_in = S_HEAD;
                  end
                  OP_NEXT: begin
                     if (cursor_valid_ff) begin
                        state_in = S_ITER;
                     end else begin
                        res_status_in = ST_END;
                     end
                  end
                  OP_POOL_RST: begin
                     pool_used_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // head word available
         S_HEAD: begin
            if (op_ff == OP_START) begin
               cursor_in       = head_node;
               cursor_valid_in = head_valid;
               state_in        = S_FINISH;
            end else if (head_valid) begin
               node_raddr = head_node;
               cur_in     = head_node;
               steps_in   = '0;
               state_in   = S_WALK;
            end else begin
               prev_in  = '0;
               state_in = S_ALLOC;
               steps_in = '0;
            end
         end

         // one list node per cycle
         S_WALK: begin
            node_raddr = rd_link;
            if (steps_ff >= CNT_W'(POOL_DEPTH)) begin
               res_status_in = ST_FULL;
               state_in      = S_FINISH;
            end else if (rd_elem == elem_ff) begin
               res_status_in = ST_PRESENT;
               state_in      = S_FINISH;
            end else begin
               prev_in      = cur_ff;
               prev_elem_in = rd_elem;
               steps_in     = steps_ff + 1'b1;
               if (rd_link_valid) begin
                  cur_in = rd_link;
               end else begin
                  state_in = S_ALLOC;
               end
            end
         end

         // read next: return element and advance cursor
         S_ITER: begin
            res_elem_in     = rd_elem;
            res_rv_in       = 1'b1;
            cursor_in       = rd_link;
            cursor_valid_in = rd_link_valid;
            state_in        = S_FINISH;
         end

         // take a fresh node from the pool
         S_ALLOC: begin
            if (pool_used_ff >= CNT_W'(POOL_DEPTH)) begin
               res_status_in = ST_FULL;
               state_in      = S_FINISH;
            end else begin
               node_we       = 1'b1;
               new_node_in   = pool_used_ff[NODE_W-1:0];
               pool_used_in  = pool_used_ff + 1'b1;
               res_status_in = ST_APPENDED;
               if (steps_ff == '0) begin
                  head_we    = 1'b1;
                  head_wdata = {1'b1, pool_used_ff[NODE_W-1:0]};
                  state_in   = S_FINISH;
               end else begin
                  state_in = S_LINK;
               end
            end
         end

         // link the tail node to the new node
         S_LINK: begin
            node_we    = 1'b1;
            node_waddr = prev_ff;
            node_wdata = {(new_node_ff == prev_ff) ? elem_ff : prev_elem_ff,
                          new_node_ff, 1'b1};
            state_in   = S_FINISH;
         end

         // hand the result to the output register
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_elem_in   = res_elem_ff;
               rsp_rv_in     = res_rv_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         init_cnt_ff     <= '0;
         pool_used_ff    <= '0;
         cursor_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         init_cnt_ff     <= init_cnt_in;
         pool_used_ff    <= pool_used_in;
         cursor_valid_ff <= cursor_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cell_ff       <= cell_in;
      elem_ff       <= elem_in;
      cursor_ff     <= cursor_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_elem_ff  <= prev_elem_in;
      new_node_ff   <= new_node_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_elem_ff   <= res_elem_in;
      res_rv_ff     <= res_rv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_rv_ff     <= rsp_rv_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_element = rsp_elem_ff;
   assign rsp_read_valid   = rsp_rv_ff;

   // pool count never runs past the pool
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_used_ff <= CNT_W'(POOL_DEPTH))
      else $error("pool count beyond pool depth");

   // allocation only writes a node that exists
   a_alloc_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC && node_we) |-> (pool_used_ff < CNT_W'(POOL_DEPTH)))
      else $error("node allocated from a full pool");

   // an element is only returned with status done
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rv_ff) |-> (rsp_status_ff == ST_DONE))
      else $error("element returned with wrong status");

   // no element means zero data
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rv_ff) |-> (rsp_elem_ff == '0))
      else $error("stray read data");

   // pool count changes only on allocation, apart from a pool reset to zero
   a_pool_step: assert property (@(posedge clock) disable iff (reset)
      (pool_used_ff != $past(pool_used_ff) && pool_used_ff != '0)
         |-> ($past(state_ff) == S_ALLOC))
      else $error("pool count changed outside allocation");

endmodule
